// ===== sv/vtt_pkg.sv =====
`default_nettype none

package vtt_pkg;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_GROUND = 3'd0,
    MODE_TEXT   = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_CS0    = 3'd3,
    MODE_CS1    = 3'd4,
    MODE_HASH   = 3'd5,
    MODE_CSI    = 3'd6
  } mode_t;

  // Token codes.
  localparam logic [3:0] TOK_TEXT_FIRST    = 4'd0;
  localparam logic [3:0] TOK_TEXT_CHAR     = 4'd1;
  localparam logic [3:0] TOK_WRAP          = 4'd2;
  localparam logic [3:0] TOK_TEXT_END      = 4'd3;
  localparam logic [3:0] TOK_CONTROL       = 4'd4;
  localparam logic [3:0] TOK_DEL           = 4'd5;
  localparam logic [3:0] TOK_HIGH_BYTE     = 4'd6;
  localparam logic [3:0] TOK_ESC_MNEMONIC  = 4'd7;
  localparam logic [3:0] TOK_BARE_ESC      = 4'd8;
  localparam logic [3:0] TOK_CHARSET       = 4'd9;
  localparam logic [3:0] TOK_HASH_MNEMONIC = 4'd10;
  localparam logic [3:0] TOK_HASH_UNKNOWN  = 4'd11;
  localparam logic [3:0] TOK_CSI_ARG       = 4'd12;
  localparam logic [3:0] TOK_CSI_FUNCTION  = 4'd13;
  localparam logic [3:0] TOK_CSI_UNKNOWN   = 4'd14;
  localparam logic [3:0] TOK_CSI_TRUNCATED = 4'd15;

  // Special bytes.
  localparam logic [7:0] BYTE_ESC      = 8'd27;
  localparam logic [7:0] BYTE_DEL      = 8'd127;
  localparam logic [7:0] BYTE_SPACE    = 8'd32;
  localparam logic [7:0] BYTE_TILDE    = 8'h7E;
  localparam logic [7:0] BYTE_LPAREN   = 8'h28;
  localparam logic [7:0] BYTE_RPAREN   = 8'h29;
  localparam logic [7:0] BYTE_HASH     = 8'h23;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [7:0] WRAP_RESET    = 8'd40;

  // Depth of the output token queue; the pointers wrap, so it stays a power of two.
  localparam int FIFO_DEPTH = 4;

  // One output token.
  typedef struct packed {
    logic [3:0] token;
    logic [7:0] value;
    logic       charset_set;
    logic       had_args;
    logic       last;
  } res_t;

  // Everything the decoder hands back for one request.
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
    mode_t      mode_next;
    logic [7:0] column_next;
    logic       args_next;
  } dec_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } lookup_t;

  // Simple escape table: 1 2 7 8 = > D E H M z c
  function automatic lookup_t esc_lookup(input logic [7:0] b);
    lookup_t r;
    r.hit = 1'b1;
    case (b)
      8'h31:   r.idx = 5'd0;
      8'h32:   r.idx = 5'd1;
      8'h37:   r.idx = 5'd2;
      8'h38:   r.idx = 5'd3;
      8'h3D:   r.idx = 5'd4;
      8'h3E:   r.idx = 5'd5;
      8'h44:   r.idx = 5'd6;
      8'h45:   r.idx = 5'd7;
      8'h48:   r.idx = 5'd8;
      8'h4D:   r.idx = 5'd9;
      8'h7A:   r.idx = 5'd10;
      8'h63:   r.idx = 5'd11;
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  // Line-attribute table after '#': 3 4 5 6 7 8
  function automatic lookup_t hash_lookup(input logic [7:0] b);
    lookup_t r;
    r.hit = (b >= 8'h33) && (b <= 8'h38);
    r.idx = r.hit ? 5'(b - 8'h33) : 5'd0;
    return r;
  endfunction

  // CSI function table: A B C D H J K R c f g h l m n q r x y
  function automatic lookup_t csi_lookup(input logic [7:0] b);
    lookup_t r;
    r.hit = 1'b1;
    case (b)
      8'h41:   r.idx = 5'd0;
      8'h42:   r.idx = 5'd1;
      8'h43:   r.idx = 5'd2;
      8'h44:   r.idx = 5'd3;
      8'h48:   r.idx = 5'd4;
      8'h4A:   r.idx = 5'd5;
      8'h4B:   r.idx = 5'd6;
      8'h52:   r.idx = 5'd7;
      8'h63:   r.idx = 5'd8;
      8'h66:   r.idx = 5'd9;
      8'h67:   r.idx = 5'd10;
      8'h68:   r.idx = 5'd11;
      8'h6C:   r.idx = 5'd12;
      8'h6D:   r.idx = 5'd13;
      8'h6E:   r.idx = 5'd14;
      8'h71:   r.idx = 5'd15;
      8'h72:   r.idx = 5'd16;
      8'h78:   r.idx = 5'd17;
      8'h79:   r.idx = 5'd18;
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  function automatic res_t make_res(input logic [3:0] tok, input logic [7:0] val,
                                    input logic cs, input logic ha);
    res_t r;
    r.token       = tok;
    r.value       = val;
    r.charset_set = cs;
    r.had_args    = ha;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/vtt_decode.sv =====
`default_nettype none

// Per-byte decision logic: from the current parser state and one request,
// produce up to two tokens and the next parser state.
module vtt_decode
  import vtt_pkg::*;
(
  input  wire mode_t      mode,
  input  wire logic [7:0] column_count,
  input  wire logic       args_seen,
  input  wire logic [7:0] wrap_columns,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_stream,
  output dec_t            dec
);

  logic       printable;
  logic       is_param;
  logic       g_emit;
  res_t       g_res;
  mode_t      g_mode;
  logic [7:0] g_col;
  logic [7:0] limit;
  logic [8:0] col_inc;
  lookup_t    esc_hit;
  lookup_t    hash_hit;
  lookup_t    csi_hit;
  res_t       r0;
  res_t       r1;
  logic [1:0] n;

  assign printable = (data_byte >= BYTE_SPACE) && (data_byte <= BYTE_TILDE);
  assign is_param  = ((data_byte >= 8'h30) && (data_byte <= 8'h39)) ||
                     ((data_byte >= 8'h3B) && (data_byte <= 8'h3F));
  assign limit     = (wrap_columns == 8'd0) ? 8'd1 : wrap_columns;
  assign col_inc   = {1'b0, column_count} + 9'd1;
  assign esc_hit   = esc_lookup(data_byte);
  assign hash_hit  = hash_lookup(data_byte);
  assign csi_hit   = csi_lookup(data_byte);

  // Handling of a byte as it would be seen in ground mode.
  always_comb begin
    g_emit = 1'b1;
    g_mode = MODE_GROUND;
    g_col  = column_count;
    if (printable) begin
      g_res  = make_res(TOK_TEXT_FIRST, data_byte, 1'b0, 1'b0);
      g_mode = MODE_TEXT;
      g_col  = 8'd1;
    end else if (data_byte == BYTE_ESC) begin
      g_res  = make_res(TOK_CONTROL, data_byte, 1'b0, 1'b0);
      g_emit = 1'b0;
      g_mode = MODE_ESC;
    end else if (data_byte < BYTE_SPACE) begin
      g_res  = make_res(TOK_CONTROL, data_byte, 1'b0, 1'b0);
    end else if (data_byte == BYTE_DEL) begin
      g_res  = make_res(TOK_DEL, data_byte, 1'b0, 1'b0);
    end else begin
      g_res  = make_res(TOK_HIGH_BYTE, data_byte, 1'b0, 1'b0);
    end
  end

  // Mode dispatch.
  always_comb begin
    n              = 2'd0;
    r0             = '0;
    r1             = '0;
    dec.mode_next  = mode;
    dec.column_next = column_count;
    dec.args_next  = args_seen;
    if (end_of_stream) begin
      // Flush whatever is open and return to ground.
      n = 2'd1;
      unique case (mode)
        MODE_TEXT: r0 = make_res(TOK_TEXT_END, 8'd0, 1'b0, 1'b0);
        MODE_ESC:  r0 = make_res(TOK_BARE_ESC, BYTE_ESC, 1'b0, 1'b0);
        MODE_CS0:  r0 = make_res(TOK_BARE_ESC, BYTE_LPAREN, 1'b0, 1'b0);
        MODE_CS1:  r0 = make_res(TOK_BARE_ESC, BYTE_RPAREN, 1'b0, 1'b0);
        MODE_HASH: r0 = make_res(TOK_BARE_ESC, BYTE_HASH, 1'b0, 1'b0);
        MODE_CSI:  r0 = make_res(TOK_CSI_TRUNCATED, 8'd0, 1'b0, args_seen);
        default:   n  = 2'd0;
      endcase
      dec.mode_next   = MODE_GROUND;
      dec.column_next = 8'd0;
      dec.args_next   = 1'b0;
    end else begin
      unique case (mode)
        MODE_TEXT: begin
          if (printable) begin
            if (col_inc > {1'b0, limit}) begin
              r0 = make_res(TOK_WRAP, 8'd0, 1'b0, 1'b0);
              r1 = make_res(TOK_TEXT_CHAR, data_byte, 1'b0, 1'b0);
              n  = 2'd2;
              dec.column_next = 8'd1;
            end else begin
              r0 = make_res(TOK_TEXT_CHAR, data_byte, 1'b0, 1'b0);
              n  = 2'd1;
              dec.column_next = col_inc[7:0];
            end
          end else begin
            // Run ends; the byte itself is then a ground byte.
            r0 = make_res(TOK_TEXT_END, 8'd0, 1'b0, 1'b0);
            r1 = g_res;
            n  = g_emit ? 2'd2 : 2'd1;
            dec.mode_next   = g_mode;
            dec.column_next = 8'd0;
          end
        end
        MODE_ESC: begin
          dec.mode_next = MODE_GROUND;
          if (data_byte == BYTE_LPAREN) begin
            dec.mode_next = MODE_CS0;
          end else if (data_byte == BYTE_RPAREN) begin
            dec.mode_next = MODE_CS1;
          end else if (data_byte == BYTE_HASH) begin
            dec.mode_next = MODE_HASH;
          end else if (data_byte == BYTE_LBRACKET) begin
            dec.mode_next = MODE_CSI;
            dec.args_next = 1'b0;
          end else if (esc_hit.hit) begin
            r0 = make_res(TOK_ESC_MNEMONIC, {3'b000, esc_hit.idx}, 1'b0, 1'b0);
            n  = 2'd1;
          end else begin
            // Unknown follower: bare escape, then reprocess the byte.
            r0 = make_res(TOK_BARE_ESC, BYTE_ESC, 1'b0, 1'b0);
            r1 = g_res;
            n  = g_emit ? 2'd2 : 2'd1;
            dec.mode_next   = g_mode;
            dec.column_next = g_col;
          end
        end
        MODE_CS0, MODE_CS1: begin
          r0 = make_res(TOK_CHARSET, data_byte, (mode == MODE_CS1), 1'b0);
          n  = 2'd1;
          dec.mode_next = MODE_GROUND;
        end
        MODE_HASH: begin
          if (hash_hit.hit) begin
            r0 = make_res(TOK_HASH_MNEMONIC, {3'b000, hash_hit.idx}, 1'b0, 1'b0);
          end else begin
            r0 = make_res(TOK_HASH_UNKNOWN, data_byte, 1'b0, 1'b0);
          end
          n = 2'd1;
          dec.mode_next = MODE_GROUND;
        end
        MODE_CSI: begin
          n = 2'd1;
          if (is_param) begin
            r0 = make_res(TOK_CSI_ARG, data_byte, 1'b0, 1'b0);
            dec.args_next = 1'b1;
          end else begin
            if (csi_hit.hit) begin
              r0 = make_res(TOK_CSI_FUNCTION, {3'b000, csi_hit.idx}, 1'b0, args_seen);
            end else begin
              r0 = make_res(TOK_CSI_UNKNOWN, data_byte, 1'b0, args_seen);
            end
            dec.mode_next = MODE_GROUND;
            dec.args_next = 1'b0;
          end
        end
        default: begin
          // Ground, and any unused mode code.
          r0 = g_res;
          n  = g_emit ? 2'd1 : 2'd0;
          dec.mode_next   = g_mode;
          dec.column_next = g_col;
        end
      endcase
    end

    // Mark the final token of this request.
    r0.last   = (n == 2'd1);
    r1.last   = (n == 2'd2);
    dec.count = n;
    dec.res0  = r0;
    dec.res1  = r1;
  end

endmodule

`default_nettype wire

// ===== sv/vt100_escape_tokenizer.sv =====
`default_nettype none

// Terminal byte stream tokenizer.
// Input stream: s_axis_tdata[7:0] carries one terminal byte; s_axis_tuser set
// marks end of stream, which carries no byte and flushes any open text run or
// escape sequence. Output stream: each request gives zero, one or two tokens;
// m_axis_tlast marks the final token caused by one request.
// Configuration: cfg_wr_en writes cfg_wr_data into the wrap column count
// (reset 40, zero acts as one); write only while the block is idle.
// The tokens of a request are written into the output queue as the request
// is accepted, by a single combinational decode pass, so a request can be
// accepted every cycle while s_axis_tready is high; a request that gives two
// tokens drains one per output transfer; the FIFO_DEPTH-entry queue absorbs it.
// s_axis_tready is high while at least two queue entries are free.
// When the receiver stalls, tokens wait in the queue with their data held,
// and input is refused once fewer than two entries remain free.
// Reset (rst, synchronous) empties the queue, returns the parser to ground
// mode and restores the wrap column count.
module vt100_escape_tokenizer
  import vtt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tuser,  // [0] end_of_stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [3:0] token, [11:4] value, zero above
  output logic [1:0]       m_axis_tuser,  // [0] charset_set, [1] had_args
  output logic             m_axis_tlast
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]    wrap_columns;
  mode_t         mode;
  logic [7:0]    column_count;
  logic          args_seen;
  dec_t          dec;
  res_t          queue [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          s_fire;
  logic          m_fire;
  logic [1:0]    push_n;
  res_t          head;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign push_n = s_fire ? dec.count : 2'd0;

  // Wrap column register.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_columns <= WRAP_RESET;
    end else if (cfg_wr_en) begin
      wrap_columns <= cfg_wr_data;
    end
  end

  vtt_decode u_decode (
    .mode          (mode),
    .column_count  (column_count),
    .args_seen     (args_seen),
    .wrap_columns  (wrap_columns),
    .data_byte     (s_axis_tdata),
    .end_of_stream (s_axis_tuser),
    .dec           (dec)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_GROUND;
      column_count <= 8'd0;
      args_seen    <= 1'b0;
    end else if (s_fire) begin
      mode         <= dec.mode_next;
      column_count <= dec.column_next;
      args_seen    <= dec.args_next;
    end
  end

  // Token queue storage.
  always_ff @(posedge clk) begin
    if (s_fire && (dec.count != 2'd0)) begin
      queue[wr_ptr] <= dec.res0;
    end
    if (s_fire && (dec.count == 2'd2)) begin
      queue[wr_ptr + PW'(1)] <= dec.res1;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      if (m_fire) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fill <= fill + CW'(push_n) - CW'(m_fire);
    end
  end

  assign s_axis_tready = (fill <= CW'(FIFO_DEPTH - 2));
  assign m_axis_tvalid = (fill != '0);
  assign head          = queue[rd_ptr];
  assign m_axis_tdata  = {4'b0000, head.value, head.token};
  assign m_axis_tuser  = {head.had_args, head.charset_set};
  assign m_axis_tlast  = head.last;

endmodule

`default_nettype wire

// ===== sv/vtt_checker.sv =====
`default_nettype none

// Port-level checks for the tokenizer.
module vtt_checker
  import vtt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A stalled token keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled token changed");

  // A wrap is always followed by the character that caused it.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[3:0] == TOK_WRAP) |-> !m_axis_tlast)
    else $error("wrap token marked last");

  // The charset flag appears only on charset tokens.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[3:0] == TOK_CHARSET))
    else $error("charset flag on wrong token");

  // The argument flag appears only on tokens that close a CSI sequence.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata[3:0] == TOK_CSI_FUNCTION) ||
      (m_axis_tdata[3:0] == TOK_CSI_UNKNOWN) ||
      (m_axis_tdata[3:0] == TOK_CSI_TRUNCATED))
    else $error("argument flag on wrong token");

  // The queue is empty right after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("token present after reset");

endmodule

bind vt100_escape_tokenizer vtt_checker u_vtt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
